@@ design/intrinsic_plasticity_update_unit_defines.svh @@
// Assertion macros for the port-level checker of the plasticity update unit.
// No dependencies; included by bare file name.
`ifndef INTRINSIC_PLASTICITY_UPDATE_UNIT_DEFINES_SVH
`define INTRINSIC_PLASTICITY_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IPU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ipu_pkg.sv @@
// Package for the plasticity update unit: sizes, register codes, stage structs,
// and the Q16.16 saturation helpers. No dependencies.
package ipu_pkg;

	localparam int UNITS       = 256;
	localparam int IDX_W       = 8;
	localparam int AW          = $clog2(UNITS);
	localparam int Q_W         = 32;
	localparam int LR_W        = 16;
	localparam int M_W         = 24;
	localparam int C_W         = 25;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int RECIP_STEPS = 33;

	localparam logic signed [31:0] ONE_Q16   = 32'sh0001_0000;
	localparam logic [C_W-1:0]     TWO_Q16   = 25'h002_0000;
	localparam logic signed [63:0] S32_MAX64 = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN64 = 64'shFFFF_FFFF_8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARN_RATE = 2'd0,
		REG_INV_MEAN   = 2'd1
	} cfg_reg_t;

	// item payload traveling through the term and reciprocal pipelines
	typedef struct packed {
		logic [IDX_W-1:0]    unit;
		logic                inr;
		logic signed [31:0]  a;
		logic signed [31:0]  b;
		logic signed [33:0]  part_a;
		logic signed [33:0]  sum_b;
		logic                flag;
	} side_t;

	// finished update
	typedef struct packed {
		logic [IDX_W-1:0]    unit;
		logic                inr;
		logic signed [31:0]  gain;
		logic signed [31:0]  bias;
		logic                flag;
	} res_t;

	// {overflow, clamped value}
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] res;
		if (v > S32_MAX64) res = {1'b1, 32'h7FFF_FFFF};
		else if (v < S32_MIN64) res = {1'b1, 32'h8000_0000};
		else res = {1'b0, v[31:0]};
		return res;
	endfunction

	// Q16.16 product: floor shift, then clamp
	function automatic logic [32:0] qsat(input logic signed [63:0] prod);
		logic signed [63:0] sh;
		sh = prod >>> 16;
		return sat32(sh);
	endfunction

endpackage

@@ design/ipu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

@@ design/ipu_terms.sv @@
// Product pipeline: forms the x/y terms of both update sums in four stages.
// Depends on ipu_pkg.
module ipu_terms (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  ipu_pkg::side_t            in_side,
	input  logic signed [31:0]        x,
	input  logic signed [31:0]        y,
	input  logic [ipu_pkg::M_W-1:0]   m,
	input  logic [ipu_pkg::C_W-1:0]   c,
	output logic                      out_vld,
	output ipu_pkg::side_t            out_side
);

	logic signed [25:0] c_s;
	logic signed [24:0] m_s;

	// stage 1
	logic               vld_s1;
	ipu_pkg::side_t     side_s1;
	logic signed [63:0] xy_p_s1, yy_p_s1;
	logic signed [57:0] cy_p_s1;
	logic signed [31:0] x_s1, y_s1;

	// stage 2
	logic               vld_s2;
	ipu_pkg::side_t     side_s2;
	logic signed [63:0] xyy_p_s2;
	logic signed [57:0] cxy_p_s2;
	logic signed [56:0] myy_p_s2;
	logic signed [31:0] cy_s2, x_s2;
	logic               flag_s2;

	// stage 3
	logic               vld_s3;
	ipu_pkg::side_t     side_s3;
	logic signed [56:0] mxyy_p_s3;
	logic signed [31:0] cxy_s3, myy_s3, cy_s3, x_s3;
	logic               flag_s3;

	logic [32:0] xy_r, yy_r, cy_r, xyy_r, cxy_r, myy_r, mxyy_r;

	// stage 3 payload with both sums filled in
	ipu_pkg::side_t     side_fin;

	assign c_s = $signed({1'b0, c});
	assign m_s = $signed({1'b0, m});

	assign xy_r   = ipu_pkg::qsat(xy_p_s1);
	assign yy_r   = ipu_pkg::qsat(yy_p_s1);
	assign cy_r   = ipu_pkg::qsat(64'(cy_p_s1));
	assign xyy_r  = ipu_pkg::qsat(xyy_p_s2);
	assign cxy_r  = ipu_pkg::qsat(64'(cxy_p_s2));
	assign myy_r  = ipu_pkg::qsat(64'(myy_p_s2));
	assign mxyy_r = ipu_pkg::qsat(64'(mxyy_p_s3));

	always_comb begin
		side_fin        = side_s3;
		side_fin.part_a = 34'(x_s3) - 34'(cxy_s3) + 34'($signed(mxyy_r[31:0]));
		side_fin.sum_b  = 34'(ipu_pkg::ONE_Q16) - 34'(cy_s3) + 34'(myy_s3);
		side_fin.flag   = flag_s3 | mxyy_r[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			xy_p_s1 <= x * y;
			yy_p_s1 <= y * y;
			cy_p_s1 <= c_s * y;
			x_s1    <= x;
			y_s1    <= y;

			side_s2  <= side_s1;
			xyy_p_s2 <= $signed(xy_r[31:0]) * y_s1;
			cxy_p_s2 <= c_s * $signed(xy_r[31:0]);
			myy_p_s2 <= m_s * $signed(yy_r[31:0]);
			cy_s2    <= cy_r[31:0];
			x_s2     <= x_s1;
			flag_s2  <= side_s1.flag | xy_r[32] | yy_r[32] | cy_r[32];

			side_s3   <= side_s2;
			mxyy_p_s3 <= m_s * $signed(xyy_r[31:0]);
			cxy_s3    <= cxy_r[31:0];
			myy_s3    <= myy_r[31:0];
			cy_s3     <= cy_s2;
			x_s3      <= x_s2;
			flag_s3   <= flag_s2 | xyy_r[32] | cxy_r[32] | myy_r[32];

			out_side <= side_fin;
		end
	end

endmodule

@@ design/ipu_recip.sv @@
// Pipelined reciprocal 2^32 / a, one quotient bit per stage, with payload alongside.
// Depends on ipu_pkg.
module ipu_recip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  ipu_pkg::side_t     in_side,
	output logic               out_vld,
	output ipu_pkg::side_t     out_side,
	output logic signed [31:0] recip,
	output logic               recip_sat
);

	localparam int N = ipu_pkg::RECIP_STEPS;

	logic           vld_q  [N+1];
	logic [31:0]    rem_q  [N+1];
	logic [32:0]    quo_q  [N+1];
	logic [31:0]    den_q  [N+1];
	logic           neg_q  [N+1];
	logic           zero_q [N+1];
	ipu_pkg::side_t side_q [N+1];

	// setup: magnitude and sign of the gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q[0] <= 1'b0;
		else if (en) vld_q[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0]  <= in_side.a[31] ? 32'(-in_side.a) : in_side.a;
			neg_q[0]  <= in_side.a[31];
			zero_q[0] <= (in_side.a == '0);
			rem_q[0]  <= '0;
			quo_q[0]  <= '0;
			side_q[0] <= in_side;
		end
	end

	// restoring steps; the dividend is a single one at bit 32
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [32:0] sh;
		logic [32:0] diff;
		logic        ge;

		assign sh   = {rem_q[k], 1'(k == 0)};
		assign diff = sh - {1'b0, den_q[k]};
		assign ge   = (sh >= {1'b0, den_q[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[k+1] <= 1'b0;
			else if (en) vld_q[k+1] <= vld_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= ge ? diff[31:0] : sh[31:0];
				quo_q[k+1]  <= {quo_q[k][31:0], ge};
				den_q[k+1]  <= den_q[k];
				neg_q[k+1]  <= neg_q[k];
				zero_q[k+1] <= zero_q[k];
				side_q[k+1] <= side_q[k];
			end
		end
	end

	// sign and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= vld_q[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= side_q[N];
			if (zero_q[N]) begin
				recip     <= 32'sh7FFF_FFFF;
				recip_sat <= 1'b1;
			end else if (!neg_q[N]) begin
				recip_sat <= (quo_q[N] > 33'h0_7FFF_FFFF);
				recip     <= (quo_q[N] > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_q[N][31:0];
			end else begin
				recip_sat <= (quo_q[N] > 33'h0_8000_0000);
				recip     <= (quo_q[N] > 33'h0_8000_0000) ? 32'sh8000_0000
					: 32'(-quo_q[N]);
			end
		end
	end

endmodule

@@ design/ipu_update.sv @@
// Final update: scales both sums by the learning rate and adds to gain and bias.
// Depends on ipu_pkg.
module ipu_update (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  ipu_pkg::side_t             in_side,
	input  logic signed [31:0]         recip,
	input  logic                       recip_sat,
	input  logic [ipu_pkg::LR_W-1:0]   lr,
	output logic                       out_vld,
	output ipu_pkg::res_t              out_res
);

	logic signed [34:0] sum_a;
	logic signed [16:0] lr_s;

	logic               vld_s1;
	logic signed [51:0] pa_s1, pb_s1;
	logic signed [31:0] a_s1, b_s1;
	logic [ipu_pkg::IDX_W-1:0] unit_s1;
	logic               inr_s1, flag_s1;

	logic signed [36:0] na, nb;
	logic [32:0]        na_r, nb_r;

	assign sum_a = 35'(recip) + 35'(in_side.part_a);
	assign lr_s  = $signed({1'b0, lr});

	assign na   = 37'(a_s1) + 37'(pa_s1 >>> 16);
	assign nb   = 37'(b_s1) + 37'(pb_s1 >>> 16);
	assign na_r = ipu_pkg::sat32(64'(na));
	assign nb_r = ipu_pkg::sat32(64'(nb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1   <= lr_s * sum_a;
			pb_s1   <= 52'(lr_s * in_side.sum_b);
			a_s1    <= in_side.a;
			b_s1    <= in_side.b;
			unit_s1 <= in_side.unit;
			inr_s1  <= in_side.inr;
			flag_s1 <= in_side.flag | recip_sat;

			out_res.unit <= unit_s1;
			out_res.inr  <= inr_s1;
			out_res.gain <= na_r[31:0];
			out_res.bias <= nb_r[31:0];
			out_res.flag <= flag_s1 | na_r[32] | nb_r[32];
		end
	end

endmodule

@@ design/intrinsic_plasticity_update_unit.sv @@
// Top level of the intrinsic plasticity update unit (per-unit gain/bias learning).
// Depends on ipu_pkg, ipu_ram, ipu_terms, ipu_recip, ipu_update.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | to block  | in_valid / in_ready   | unit_index, net_input, activation
//  out     | from block| out_valid / out_ready | unit_echo, new_gain, new_bias, saturated
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transfer per cycle sustained while out_ready holds and no unit in flight is resent.
// The reciprocal takes one quotient bit per stage (33 stages) and sets most of the depth.
// A unit still in flight blocks a new transfer for that same unit until its write-back.
// Reset: 256 valid bits make every unit read as gain 1.0, bias 0 until first written.
// A full output register with out_ready low freezes every stage; nothing is lost.
module intrinsic_plasticity_update_unit (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ipu_pkg::IDX_W-1:0]         unit_index,
	input  logic signed [31:0]                net_input,
	input  logic signed [31:0]                activation,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ipu_pkg::IDX_W-1:0]         unit_echo,
	output logic signed [31:0]                new_gain,
	output logic signed [31:0]                new_bias,
	output logic                              saturated,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = ipu_pkg::AW;

	// config registers
	logic [ipu_pkg::LR_W-1:0] lr_q;
	logic [ipu_pkg::M_W-1:0]  m_q;
	logic [ipu_pkg::C_W-1:0]  c;

	// global advance: the whole pipe moves unless the output is stuck
	logic advance;
	logic accept;
	logic [AW-1:0] in_addr;

	// per-unit tracking
	logic [ipu_pkg::UNITS-1:0] busy_q;   // item for this unit in flight
	logic [ipu_pkg::UNITS-1:0] init_q;   // store entry written at least once

	// stage 1: RAM read data lines up here
	logic               vld_s1;
	logic signed [31:0] x_s1, y_s1;
	logic [ipu_pkg::IDX_W-1:0] unit_s1;
	logic               inr_s1, init_s1;
	logic [63:0]        rdata;
	ipu_pkg::side_t     side_s1;

	logic               terms_vld, recip_vld, fin_vld;
	ipu_pkg::side_t     terms_side, recip_side;
	logic signed [31:0] recip;
	logic               recip_sat;
	ipu_pkg::res_t      fin;
	logic               wb;
	logic [AW-1:0]      fin_addr;

	logic               out_valid_q;

	assign c         = {1'b0, m_q} + ipu_pkg::TWO_Q16;
	assign cfg_ready = 1'b1;

	assign advance  = !out_valid_q || out_ready;
	assign in_addr  = unit_index[AW-1:0];
	assign in_ready = advance && !busy_q[in_addr];
	assign accept   = in_valid && in_ready;

	assign fin_addr = fin.unit[AW-1:0];
	assign wb       = advance && fin_vld && fin.inr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 16'd655;
			m_q  <= 24'd327680;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ipu_pkg::REG_LEARN_RATE: lr_q <= cfg_data[ipu_pkg::LR_W-1:0];
				ipu_pkg::REG_INV_MEAN:   m_q  <= cfg_data[ipu_pkg::M_W-1:0];
				default: ;
			endcase
		end
	end

	// gain in the upper half, bias in the lower half
	ipu_ram #(
		.WIDTH (64),
		.DEPTH (ipu_pkg::UNITS)
	) u_store (
		.clk   (clk),
		.we    (wb),
		.waddr (fin_addr),
		.wdata ({fin.gain, fin.bias}),
		.re    (advance),
		.raddr (in_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			init_q <= '0;
		end else begin
			if (advance && fin_vld) busy_q[fin_addr] <= 1'b0;
			if (accept) busy_q[in_addr] <= 1'b1;
			if (wb) init_q[fin_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (advance) vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1    <= net_input;
			y_s1    <= activation;
			unit_s1 <= unit_index;
			inr_s1  <= ({1'b0, unit_index} < (ipu_pkg::IDX_W + 1)'(ipu_pkg::UNITS));
			init_s1 <= init_q[in_addr];
		end
	end

	always_comb begin
		side_s1        = '0;
		side_s1.unit   = unit_s1;
		side_s1.inr    = inr_s1;
		side_s1.a      = init_s1 ? $signed(rdata[63:32]) : ipu_pkg::ONE_Q16;
		side_s1.b      = init_s1 ? $signed(rdata[31:0]) : 32'sd0;
	end

	ipu_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_vld   (vld_s1),
		.in_side  (side_s1),
		.x        (x_s1),
		.y        (y_s1),
		.m        (m_q),
		.c        (c),
		.out_vld  (terms_vld),
		.out_side (terms_side)
	);

	ipu_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_vld    (terms_vld),
		.in_side   (terms_side),
		.out_vld   (recip_vld),
		.out_side  (recip_side),
		.recip     (recip),
		.recip_sat (recip_sat)
	);

	ipu_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_vld    (recip_vld),
		.in_side   (recip_side),
		.recip     (recip),
		.recip_sat (recip_sat),
		.lr        (lr_q),
		.out_vld   (fin_vld),
		.out_res   (fin)
	);

	// output register; units out of range report zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (advance) out_valid_q <= fin_vld;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			unit_echo <= fin.unit;
			new_gain  <= fin.inr ? fin.gain : 32'sd0;
			new_bias  <= fin.inr ? fin.bias : 32'sd0;
			saturated <= fin.inr && fin.flag;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/ipu_checker.sv @@
// Port-level checker for the plasticity update unit, bound to the top level.
// Depends on ipu_pkg and intrinsic_plasticity_update_unit_defines.svh.
`include "intrinsic_plasticity_update_unit_defines.svh"

module ipu_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [ipu_pkg::IDX_W-1:0]      unit_index,
	input logic signed [31:0]             net_input,
	input logic signed [31:0]             activation,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [ipu_pkg::IDX_W-1:0]      unit_echo,
	input logic signed [31:0]             new_gain,
	input logic signed [31:0]             new_bias,
	input logic                           saturated,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data
);

	// a unit just taken may not be taken again the next cycle
	`IPU_ASSERT_NEXT(a_same_unit_interlock, in_valid && in_ready,
		!(in_valid && in_ready && unit_index == $past(unit_index)), "same unit re-accepted")

	// a stuck output freezes the input side
	`IPU_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready,
		"input accepted while output stalled")

	`IPU_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid,
		"out_valid dropped without transfer")

	`IPU_ASSERT_NEXT(a_out_payload_holds, out_valid && !out_ready,
		$stable(unit_echo) && $stable(new_gain) && $stable(new_bias) && $stable(saturated),
		"output payload changed while stalled")

endmodule

bind intrinsic_plasticity_update_unit ipu_checker u_chk (.*);

@@ bench/intrinsic_plasticity_update_unit_checker.sv @@
// Scoreboard for the plasticity update unit: watches the input, output and config
// transfers, keeps its own gain/bias tables and compares every result. Depends on ipu_pkg.
`timescale 1ns / 1ps

module intrinsic_plasticity_update_unit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [ipu_pkg::IDX_W-1:0]      unit_index,
	input  logic signed [31:0]             net_input,
	input  logic signed [31:0]             activation,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [ipu_pkg::IDX_W-1:0]      unit_echo,
	input  logic signed [31:0]             new_gain,
	input  logic signed [31:0]             new_bias,
	input  logic                           saturated,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending
);

	typedef struct packed {
		logic [7:0]         unit;
		logic signed [31:0] gain;
		logic signed [31:0] bias;
		logic               sat;
	} update_t;

	localparam longint HI = 64'sd2147483647;
	localparam longint LO = -64'sd2147483648;

	logic signed [31:0] gain_tbl [ipu_pkg::UNITS];
	logic signed [31:0] bias_tbl [ipu_pkg::UNITS];
	logic [15:0] lr_q;
	logic [23:0] inv_mu_q;
	update_t expected_updates [$];

	assign pending = expected_updates.size();

	function automatic longint clip(input longint v, inout logic f);
		if (v > HI) begin
			f = 1'b1;
			return HI;
		end
		if (v < LO) begin
			f = 1'b1;
			return LO;
		end
		return v;
	endfunction

	// exact product, floor by 2^16, clamp
	function automatic longint qprod(input longint p, input longint q, inout logic f);
		return clip((p * q) >>> 16, f);
	endfunction

	function automatic update_t learn(input logic [7:0] u, input longint x, input longint y);
		update_t r;
		logic f;
		longint a, b, rc, xy, xyy, yy, m, c, lr, sa, sb;
		f = 1'b0;
		r.unit = u;
		if (u >= ipu_pkg::UNITS) begin
			r.gain = 0;
			r.bias = 0;
			r.sat = 0;
			return r;
		end
		m = inv_mu_q;
		c = 2 * 65536 + m;
		lr = lr_q;
		a = gain_tbl[u];
		b = bias_tbl[u];
		if (a == 0) begin
			rc = HI;
			f = 1'b1;
		end else
			rc = clip(64'sd4294967296 / a, f);
		xy = qprod(x, y, f);
		xyy = qprod(xy, y, f);
		yy = qprod(y, y, f);
		sa = rc + x - qprod(c, xy, f) + qprod(m, xyy, f);
		sb = 65536 - qprod(c, y, f) + qprod(m, yy, f);
		r.gain = 32'(clip(a + ((lr * sa) >>> 16), f));
		r.bias = 32'(clip(b + ((lr * sb) >>> 16), f));
		r.sat = f;
		gain_tbl[u] = r.gain;
		bias_tbl[u] = r.bias;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		update_t got, exp_u;
		if (!arst_n) begin
			for (int i = 0; i < ipu_pkg::UNITS; i++) begin
				gain_tbl[i] = 65536;
				bias_tbl[i] = 0;
			end
			lr_q = 16'd655;
			inv_mu_q = 24'd327680;
			fail_count = 0;
			expected_updates.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ipu_pkg::REG_LEARN_RATE) lr_q = cfg_data[15:0];
				else if (cfg_index == ipu_pkg::REG_INV_MEAN) inv_mu_q = cfg_data;
			end
			if (in_valid && in_ready)
				expected_updates.push_back(learn(unit_index, net_input, activation));
			if (out_valid && out_ready) begin
				got = '{unit_echo, new_gain, new_bias, saturated};
				if (expected_updates.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %h", got);
				end else begin
					exp_u = expected_updates.pop_front();
					if (got !== exp_u) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp u=%0d g=%h b=%h s=%b got u=%0d g=%h b=%h s=%b",
								exp_u.unit, exp_u.gain, exp_u.bias, exp_u.sat,
								got.unit, got.gain, got.bias, got.sat);
					end
				end
			end
		end
	end
endmodule

@@ bench/intrinsic_plasticity_update_unit_tb.sv @@
// Testbench top for the plasticity update unit: clock, reset, stimulus, verdict.
// Depends on ipu_pkg, the unit RTL and intrinsic_plasticity_update_unit_checker.
`timescale 1ns / 1ps

module intrinsic_plasticity_update_unit_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [ipu_pkg::IDX_W-1:0] unit_index = '0;
	logic signed [31:0] net_input = '0, activation = '0;
	logic out_valid, out_ready = 1'b0;
	logic [ipu_pkg::IDX_W-1:0] unit_echo;
	logic signed [31:0] new_gain, new_bias;
	logic saturated;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [ipu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pending;

	always #1 clk = ~clk;

	intrinsic_plasticity_update_unit i_dut (.*);
	intrinsic_plasticity_update_unit_checker i_chk (.*);

	// gap length: mostly zero or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// valid stays high after the transfer; a gap or a drain lowers it
	task automatic send(input logic [7:0] u, input logic [31:0] x, input logic [31:0] y);
		in_valid <= 1'b1;
		unit_index <= u;
		net_input <= x;
		activation <= y;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic pace();
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic write_reg(input ipu_pkg::cfg_reg_t idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// idle the block before a register write: drain, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// value mix: extremes, small Q16.16 magnitudes, anything
	function automatic logic [31:0] pick_q();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
			5, 6: return $urandom_range(0, 32'h1_0000);
			default: return $urandom;
		endcase
	endfunction

	// receiver back-pressure
	always begin
		int g;
		@(negedge clk);
		out_ready <= 1'b1;
		g = gap_len();
		if (g != 0) begin
			@(negedge clk);
			out_ready <= 1'b0;
			repeat (g) @(negedge clk);
		end
	end

	initial begin
		logic [23:0] lr_set [4];
		logic [23:0] mu_set [4];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset gains, extremes, zero and hot units
		send(8'd0, 32'h0, 32'h0);
		send(8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(8'd1, 32'h8000_0000, 32'h8000_0000);
		send(8'd2, 32'h7FFF_FFFF, 32'h8000_0000);
		send(8'd3, 32'h0001_0000, 32'h0000_8000);
		send(8'd3, 32'hFFFF_0000, 32'h0001_0000);
		send(8'd0, 32'h0, 32'h0);
		send(8'd128, 32'hFFFF_FFFF, 32'h0000_0001);
		drain();
		write_reg(ipu_pkg::REG_LEARN_RATE, 24'h00_FFFF);
		write_reg(ipu_pkg::REG_INV_MEAN, 24'hFF_FFFF);
		// drive a gain toward zero and past it
		for (int i = 0; i < 6; i++) send(8'd7, 32'h8000_0000, 32'h0);
		for (int i = 0; i < 4; i++) send(8'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(8'd9, 32'h1234_5678, 32'h8765_4321);
		drain();
		write_reg(ipu_pkg::REG_LEARN_RATE, 24'h0);
		write_reg(ipu_pkg::REG_INV_MEAN, 24'h0);
		send(8'd7, 32'h0, 32'h0);
		send(8'd10, $urandom, $urandom);

		lr_set = '{24'd655, 24'd65535, 24'd1, 24'd20000};
		mu_set = '{24'd327680, 24'd0, 24'd16777215, 24'd65536};
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_reg(ipu_pkg::REG_LEARN_RATE,
				ph == 3 ? 24'($urandom_range(0, 65535)) : lr_set[ph]);
			write_reg(ipu_pkg::REG_INV_MEAN,
				ph == 3 ? 24'($urandom_range(0, 24'hFF_FFFF)) : mu_set[ph]);
			for (int n = 0; n < 425; n++) begin
				logic [7:0] u;
				// small hot sets force same-unit interlocks
				u = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				send(u, pick_q(), pick_q());
				pace();
				if (n == 200) begin
					in_valid <= 1'b0;
					while (pending != 0) @(negedge clk);
				end
			end
		end
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+design
design/ipu_pkg.sv
design/ipu_ram.sv
design/ipu_terms.sv
design/ipu_recip.sv
design/ipu_update.sv
design/intrinsic_plasticity_update_unit.sv
design/ipu_checker.sv
bench/intrinsic_plasticity_update_unit_checker.sv
bench/intrinsic_plasticity_update_unit_tb.sv
